/* hw/rtl/bms_pkg.sv */
// shared types and constants of the bounded multiset store
package bms_pkg;

   localparam int CAPACITY    = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int OP_W        = 3;
   localparam int FIELD_CNT_W = 5;
   localparam int FIELD_VAL_W = 32;

   localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
   localparam logic [OP_W-1:0] OP_QUERY  = 3'd2;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
   localparam logic [OP_W-1:0] OP_DUMP   = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0]        req_type;
      logic [FIELD_VAL_W-1:0] value;
   } bms_req_item_type;

   typedef struct packed {
      logic                   ok;
      logic [FIELD_CNT_W-1:0] frequency;
      logic [FIELD_CNT_W-1:0] item_count;
      logic                   is_empty;
      logic [FIELD_VAL_W-1:0] entry_value;
      logic                   entry_valid;
      logic                   last;
   } bms_rsp_item_type;

   typedef struct packed {
      logic                   en;
      logic [IDX_W-1:0]       addr;
      logic [VALUE_WIDTH-1:0] data;
   } bms_wr_port_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MOVE_RD,
      ST_MOVE_WR,
      ST_DONE
   } bms_state_type;

endpackage

/* hw/rtl/bms_entry_ram.sv */
// entry memory with one write port and one registered read port
module bms_entry_ram (
   input  logic                           clock,
   input  bms_pkg::bms_wr_port_type       wr,
   input  logic                           rd_en,
   input  logic [bms_pkg::IDX_W-1:0]      rd_addr,
   output logic [bms_pkg::VALUE_WIDTH-1:0] rd_data
);
   import bms_pkg::*;

   logic [VALUE_WIDTH-1:0] entry_mem [CAPACITY];
   logic [VALUE_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         entry_mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/bounded_multiset_store.sv */
// top level of the bounded multiset store
// The store holds up to 16 values of 32 bits in one memory, with one write
// port and one registered read port, plus a live count, and works on one
// item at a time. Add, clear and unknown codes, and every code on an empty
// bag, go from acceptance to the done step, which places the result once the
// output register is free. On a non-empty bag, query, remove and dump read
// the live entries one per cycle through the single read port: a query or a
// missed remove reads them all, a remove that hits stops at the first match
// and then moves the last entry into the hole, and a dump delivers one result
// per cycle while the result side keeps up. A new item is taken once the
// previous one has placed its final result in the output register.
module bounded_multiset_store (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  bms_pkg::bms_req_item_type req_item,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output bms_pkg::bms_rsp_item_type rsp_item
);
   import bms_pkg::*;

   bms_state_type          state_ff, state_in;
   logic [OP_W-1:0]        op_ff, op_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       issue_idx_ff, issue_idx_in;
   logic [CNT_W-1:0]       chk_idx_ff, chk_idx_in;
   logic                   chk_valid_ff, chk_valid_in;
   logic [CNT_W-1:0]       freq_ff, freq_in;
   logic                   found_ff, found_in;
   logic [IDX_W-1:0]       hit_idx_ff, hit_idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   bms_rsp_item_type       rsp_item_ff, rsp_item_in;

   bms_wr_port_type        wr;
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   logic [VALUE_WIDTH-1:0] rd_data;

   logic                   slot_free;
   logic                   emit;
   bms_rsp_item_type       emit_item;
   logic [CNT_W-1:0]       last_idx;
   logic                   chk_last;
   logic                   match;
   logic                   is_dump;
   logic                   is_remove;
   logic                   scan_stall;
   logic                   scan_end;
   logic                   scan_op;

   bms_entry_ram u_entry_ram (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign last_idx   = count_ff - CNT_W'(1);
   assign chk_last   = (chk_idx_ff == last_idx);
   assign match      = (rd_data == value_ff);
   assign is_dump    = (op_ff == OP_DUMP);
   assign is_remove  = (op_ff == OP_REMOVE);
   assign scan_stall = is_dump && chk_valid_ff && !slot_free;
   assign scan_end   = chk_valid_ff && !scan_stall && (chk_last || (is_remove && match));
   assign scan_op    = (req_item.req_type == OP_REMOVE) || (req_item.req_type == OP_QUERY) ||
                       (req_item.req_type == OP_DUMP);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (scan_op && (count_ff != '0)) ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            if (scan_end) begin
               if (is_remove && match) begin
                  state_in = ST_MOVE_RD;
               end else if (is_dump) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_MOVE_RD: state_in = ST_MOVE_WR;
         ST_MOVE_WR: state_in = ST_DONE;
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      op_in        = op_ff;
      value_in     = value_ff;
      count_in     = count_ff;
      issue_idx_in = issue_idx_ff;
      chk_idx_in   = chk_idx_ff;
      chk_valid_in = chk_valid_ff;
      freq_in      = freq_ff;
      found_in     = found_ff;
      hit_idx_in   = hit_idx_ff;
      req_ready    = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = issue_idx_ff[IDX_W-1:0];
      wr.en        = 1'b0;
      wr.addr      = count_ff[IDX_W-1:0];
      wr.data      = value_ff;
      emit         = 1'b0;
      emit_item    = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in        = req_item.req_type;
               value_in     = req_item.value[VALUE_WIDTH-1:0];
               issue_idx_in = '0;
               chk_valid_in = 1'b0;
               freq_in      = '0;
               found_in     = 1'b0;
            end
         end
         ST_SCAN: begin
            if (!scan_stall) begin
               rd_en        = (issue_idx_ff < count_ff) && !scan_end;
               chk_valid_in = rd_en;
               chk_idx_in   = issue_idx_ff;
               if (rd_en) begin
                  issue_idx_in = issue_idx_ff + CNT_W'(1);
               end
               if (chk_valid_ff) begin
                  if (match) begin
                     freq_in = freq_ff + CNT_W'(1);
                  end
                  if (is_remove && match) begin
                     found_in   = 1'b1;
                     hit_idx_in = chk_idx_ff[IDX_W-1:0];
                  end
                  if (is_dump) begin
                     emit                  = 1'b1;
                     emit_item.item_count  = FIELD_CNT_W'(count_ff);
                     emit_item.entry_value = FIELD_VAL_W'(rd_data);
                     emit_item.entry_valid = 1'b1;
                     emit_item.last        = chk_last;
                  end
               end
            end
         end
         ST_MOVE_RD: begin
            rd_en   = 1'b1;
            rd_addr = last_idx[IDX_W-1:0];
         end
         ST_MOVE_WR: begin
            wr.en    = 1'b1;
            wr.addr  = hit_idx_ff;
            wr.data  = rd_data;
            count_in = last_idx;
         end
         ST_DONE: begin
            if (slot_free) begin
               emit = 1'b1;
               case (op_ff)
                  OP_ADD: begin
                     if (count_ff < CNT_W'(CAPACITY)) begin
                        wr.en        = 1'b1;
                        count_in     = count_ff + CNT_W'(1);
                        emit_item.ok = 1'b1;
                     end
                  end
                  OP_REMOVE: emit_item.ok = found_ff;
                  OP_QUERY: begin
                     emit_item.ok        = (freq_ff != '0);
                     emit_item.frequency = FIELD_CNT_W'(freq_ff);
                  end
                  OP_CLEAR: count_in = '0;
                  default: emit_item.ok = 1'b0;
               endcase
               emit_item.item_count = FIELD_CNT_W'(count_in);
               emit_item.last       = 1'b1;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
      emit_item.is_empty = (emit_item.item_count == '0);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = emit_item;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      value_ff     <= value_in;
      issue_idx_ff <= issue_idx_in;
      chk_idx_ff   <= chk_idx_in;
      freq_ff      <= freq_in;
      found_ff     <= found_in;
      hit_idx_ff   <= hit_idx_in;
      rsp_item_ff  <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("live count above capacity");

   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      emit |-> slot_free)
      else $error("result overwrites an undelivered item");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      !(wr.en && rd_en && (wr.addr == rd_addr)))
      else $error("read and write of the same entry in one cycle");

   a_count_change: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff))) |->
      ($past(state_ff == ST_DONE) || $past(state_ff == ST_MOVE_WR)))
      else $error("live count changed outside an update step");
`endif

endmodule

/* dv/bounded_multiset_store_test.sv */
// testbench for the bounded multiset store: predicts and checks every result item
`timescale 1ns / 100ps

module bounded_multiset_store_test;
   import bms_pkg::*;

   localparam int NUM_REQUESTS   = 450;
   localparam int IDLE_LIMIT     = 2000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int REPORT_LIMIT   = 10;

   class bag_scoreboard;
      logic [VALUE_WIDTH-1:0] bag_entries [CAPACITY];
      int unsigned            live_entries;
      bms_rsp_item_type       pending_rsp [$];
      int unsigned            error_count;

      function new();
         live_entries = 0;
         error_count  = 0;
      endfunction

      function string show(bms_rsp_item_type r);
         return $sformatf("ok=%0d freq=%0d count=%0d empty=%0d entry=%h valid=%0d last=%0d",
                          r.ok, r.frequency, r.item_count, r.is_empty, r.entry_value,
                          r.entry_valid, r.last);
      endfunction

      function void push_result(logic ok, int unsigned freq, logic [FIELD_VAL_W-1:0] entry,
                                logic valid, logic last);
         bms_rsp_item_type r;
         r.ok          = ok;
         r.frequency   = FIELD_CNT_W'(freq);
         r.item_count  = FIELD_CNT_W'(live_entries);
         r.is_empty    = (live_entries == 0);
         r.entry_value = entry;
         r.entry_valid = valid;
         r.last        = last;
         pending_rsp   = {pending_rsp, r};
      endfunction

      // work out the result items of one accepted request
      function void note_request(bms_req_item_type it);
         logic [VALUE_WIDTH-1:0] v;
         int unsigned            hits;
         int                     slot;
         v    = it.value[VALUE_WIDTH-1:0];
         hits = 0;
         slot = -1;
         case (it.req_type)
            OP_ADD: begin
               if (live_entries < CAPACITY) begin
                  bag_entries[live_entries] = v;
                  live_entries++;
                  push_result(1'b1, 0, '0, 1'b0, 1'b1);
               end else begin
                  push_result(1'b0, 0, '0, 1'b0, 1'b1);
               end
            end
            OP_REMOVE: begin
               for (int i = 0; i < live_entries; i++)
                  if (slot < 0 && bag_entries[i] == v) slot = i;
               if (slot >= 0) begin
                  live_entries--;
                  bag_entries[slot] = bag_entries[live_entries];
               end
               push_result(slot >= 0, 0, '0, 1'b0, 1'b1);
            end
            OP_QUERY: begin
               for (int i = 0; i < live_entries; i++)
                  if (bag_entries[i] == v) hits++;
               push_result(hits > 0, hits, '0, 1'b0, 1'b1);
            end
            OP_CLEAR: begin
               live_entries = 0;
               push_result(1'b0, 0, '0, 1'b0, 1'b1);
            end
            OP_DUMP: begin
               if (live_entries == 0)
                  push_result(1'b0, 0, '0, 1'b0, 1'b1);
               for (int i = 0; i < live_entries; i++)
                  push_result(1'b0, 0, FIELD_VAL_W'(bag_entries[i]), 1'b1,
                              i + 1 == live_entries);
            end
            default: begin
               push_result(1'b0, 0, '0, 1'b0, 1'b1);
            end
         endcase
      endfunction

      function void check_result(bms_rsp_item_type got);
         bms_rsp_item_type want;
         string            diffs;
         if (pending_rsp.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("%0t: unexpected result item: %s", $realtime, show(got));
            return;
         end
         want  = pending_rsp.pop_front();
         diffs = "";
         if (got.ok !== want.ok) diffs = {diffs, " ok"};
         if (got.frequency !== want.frequency) diffs = {diffs, " frequency"};
         if (got.item_count !== want.item_count) diffs = {diffs, " item_count"};
         if (got.is_empty !== want.is_empty) diffs = {diffs, " is_empty"};
         if (got.entry_value !== want.entry_value) diffs = {diffs, " entry_value"};
         if (got.entry_valid !== want.entry_valid) diffs = {diffs, " entry_valid"};
         if (got.last !== want.last) diffs = {diffs, " last"};
         if (diffs != "") begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
               $display("%0t: mismatch in%s", $realtime, diffs);
               $display("   expected %s", show(want));
               $display("   actual   %s", show(got));
            end
         end
      endfunction
   endclass

   logic             clock;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   bms_req_item_type req_item  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   bms_rsp_item_type rsp_item;

   bag_scoreboard          sb = new();
   logic [FIELD_VAL_W-1:0] value_pool [8];
   bit                     no_idle     = 1'b0;
   bit                     ready_level = 1'b1;
   int                     ready_hold  = 0;
   int                     idle_cycles = 0;
   int                     sent        = 0;

   bounded_multiset_store DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [FIELD_VAL_W-1:0] pick_value();
      if ($urandom_range(0, 3) == 0) return $urandom;
      return value_pool[$urandom_range(0, 7)];
   endfunction

   function automatic bms_req_item_type make_request();
      bms_req_item_type it;
      int               roll;
      roll     = $urandom_range(0, 99);
      it.value = pick_value();
      if (roll < 40) it.req_type = OP_ADD;
      else if (roll < 62) it.req_type = OP_REMOVE;
      else if (roll < 83) it.req_type = OP_QUERY;
      else if (roll < 92) it.req_type = OP_DUMP;
      else if (roll < 96) it.req_type = OP_CLEAR;
      else it.req_type = OP_W'($urandom_range(OP_DUMP + 1, (1 << OP_W) - 1));
      return it;
   endfunction

   task automatic send_request(input logic [OP_W-1:0] op, input logic [FIELD_VAL_W-1:0] v);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_item.req_type <= op;
      req_item.value    <= v;
      do @(posedge clock); while (!req_ready);
      sb.note_request(req_item);
      sent++;
   endtask

   task automatic fill_bag();
      for (int k = 0; k < CAPACITY + 2; k++) send_request(OP_ADD, pick_value());
      send_request(OP_DUMP, $urandom);
   endtask

   // result side: check accepted items and stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) sb.check_result(rsp_item);
         if (ready_hold == 0) begin
            case ($urandom_range(0, 19))
               0:         begin ready_level = 1'b0; ready_hold = $urandom_range(20, 40); end
               1, 2:      begin ready_level = 1'b0; ready_hold = $urandom_range(4, 10); end
               3, 4, 5:   begin ready_level = 1'b0; ready_hold = $urandom_range(1, 3); end
               default:   begin ready_level = 1'b1; ready_hold = $urandom_range(1, 12); end
            endcase
         end else begin
            ready_hold--;
         end
         rsp_ready <= ready_level || no_idle;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      value_pool[0] = '0;
      value_pool[1] = '1;
      for (int k = 2; k < 8; k++) value_pool[k] = $urandom;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty bag corners, unknown codes, extreme values, hit and miss removes
      send_request(OP_DUMP, 32'h0);
      send_request(OP_REMOVE, 32'h5);
      send_request(OP_QUERY, 32'h0);
      send_request(OP_W'(OP_DUMP + 1), 32'hFFFF_FFFF);
      send_request('1, 32'h0);
      send_request(OP_CLEAR, 32'hFFFF_FFFF);
      send_request(OP_ADD, 32'h0);
      send_request(OP_ADD, 32'hFFFF_FFFF);
      send_request(OP_ADD, 32'hFFFF_FFFF);
      send_request(OP_ADD, 32'h1234_5678);
      send_request(OP_QUERY, 32'hFFFF_FFFF);
      send_request(OP_QUERY, 32'h0);
      send_request(OP_REMOVE, 32'h0);
      send_request(OP_REMOVE, 32'hAAAA_5555);
      send_request(OP_DUMP, 32'h0);
      send_request(OP_REMOVE, 32'h1234_5678);
      send_request(OP_W'(OP_DUMP + 2), 32'h5555_AAAA);
      send_request(OP_CLEAR, 32'h0);
      send_request(OP_DUMP, 32'h0);

      fill_bag();
      while (sent < NUM_REQUESTS) begin
         if (sent % 30 == 0) no_idle = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 39) == 0) begin
            fill_bag();
         end else begin
            bms_req_item_type it;
            it = make_request();
            send_request(it.req_type, it.value);
         end
      end
      no_idle = 1'b0;
      req_valid <= 1'b0;

      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.error_count == 0 && sb.pending_rsp.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/bms_pkg.sv
hw/rtl/bms_entry_ram.sv
hw/rtl/bounded_multiset_store.sv
dv/bounded_multiset_store_test.sv
